[hw/rtl/rsd_pkg.sv]
package rsd_pkg;

  localparam logic [15:0] FRAME_PIXELS_RESET = 16'd64000;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0]  BYTE_SIGN_MASK = 8'h7f;
  localparam logic [15:0] WORD_SIGN_MASK = 16'h7fff;
  localparam logic [15:0] LONG_RUN_BIT   = 16'h4000;
  localparam logic [7:0]  LONG_OPCODE    = 8'h80;

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_FILL    = 2'd1,
    KIND_SKIP    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  // One entry between the parser and the pixel tracker. An entry may carry
  // only a frame start, only a command, or both.
  typedef struct packed {
    logic        start;
    logic        has_cmd;
    kind_t       kind;
    logic [7:0]  value;
    logic [14:0] count;
  } cmd_t;

endpackage

[hw/rtl/run_skip_dump_frame_decoder_core.sv]
// A byte that yields a result passes the parser queue and then the output
// register before it shows on the output. Throughput: one byte per cycle
// while byte_stall is low, set by the parser and tracker; the four-entry
// queue absorbs short output stalls without stopping input.
// Reset (rst, synchronous): no frame active, queue empty, frame size 64000.
module run_skip_dump_frame_decoder_core
  import rsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] frame_pixels,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        op_valid,
  input  logic        op_stall,
  output logic [1:0]  op_kind,
  output logic [15:0] position,
  output logic [7:0]  pixel_value,
  output logic [14:0] pixel_count,
  output logic        frame_done
);

  logic [15:0] frame_size;
  logic        accept, push, full, pop, head_valid;
  cmd_t        cmd, head;

  assign cfg_ready  = 1'b1;
  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size <= FRAME_PIXELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_size <= frame_pixels;
    end
  end

  rsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .frame_start(frame_start),
    .push       (push),
    .cmd        (cmd)
  );

  rsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  rsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .frame_size (frame_size),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .op_valid   (op_valid),
    .op_stall   (op_stall),
    .op_kind    (op_kind),
    .position   (position),
    .pixel_value(pixel_value),
    .pixel_count(pixel_count),
    .frame_done (frame_done)
  );

endmodule

[hw/rtl/rsd_front.sv]
module rsd_front
  import rsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  output logic       push,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_DUMP,
    PH_RUNCOUNT,
    PH_RUNVALUE,
    PH_WORDLOW,
    PH_WORDHIGH,
    PH_IDLE
  } phase_t;

  phase_t      phase, phase_cur, phase_next;
  logic [14:0] pending, pending_next;
  logic [7:0]  word_low, word_low_next;
  logic [15:0] word;
  logic [15:0] word_masked;
  logic [14:0] pending_dec;

  assign phase_cur   = frame_start ? PH_OPCODE : phase;
  assign word        = {data_byte, word_low};
  assign word_masked = word & WORD_SIGN_MASK;
  assign pending_dec = pending - 15'd1;

  always_comb begin
    phase_next    = phase_cur;
    pending_next  = pending;
    word_low_next = word_low;
    cmd.start     = frame_start;
    cmd.has_cmd   = 1'b0;
    cmd.kind      = KIND_SKIP;
    cmd.value     = 8'd0;
    cmd.count     = 15'd0;
    case (phase_cur)
      PH_OPCODE: begin
        if (data_byte == 8'd0) begin
          phase_next = PH_RUNCOUNT;
        end else if (data_byte < LONG_OPCODE) begin
          pending_next = {7'd0, data_byte};
          phase_next   = PH_DUMP;
        end else if (data_byte == LONG_OPCODE) begin
          phase_next = PH_WORDLOW;
        end else begin
          cmd.has_cmd = 1'b1;
          cmd.kind    = KIND_SKIP;
          cmd.count   = {7'd0, data_byte & BYTE_SIGN_MASK};
        end
      end
      PH_DUMP: begin
        pending_next = pending_dec;
        if (pending_dec == 15'd0) begin
          phase_next = PH_OPCODE;
        end
        cmd.has_cmd = 1'b1;
        cmd.kind    = KIND_LITERAL;
        cmd.value   = data_byte;
        cmd.count   = 15'd1;
      end
      PH_RUNCOUNT: begin
        pending_next = {7'd0, data_byte};
        phase_next   = PH_RUNVALUE;
      end
      PH_RUNVALUE: begin
        phase_next  = PH_OPCODE;
        cmd.has_cmd = 1'b1;
        cmd.kind    = KIND_FILL;
        cmd.value   = data_byte;
        cmd.count   = pending;
      end
      PH_WORDLOW: begin
        word_low_next = data_byte;
        phase_next    = PH_WORDHIGH;
      end
      PH_WORDHIGH: begin
        phase_next = PH_OPCODE;
        if (word == 16'd0) begin
          cmd.has_cmd = 1'b1;
          cmd.kind    = KIND_END;
          phase_next  = PH_IDLE;
        end else if (!word[15]) begin
          cmd.has_cmd = 1'b1;
          cmd.kind    = KIND_SKIP;
          cmd.count   = word[14:0];
        end else if (word_masked >= LONG_RUN_BIT) begin
          pending_next = {1'b0, word_masked[13:0]};
          phase_next   = PH_RUNVALUE;
        end else begin
          pending_next = {1'b0, word_masked[13:0]};
          phase_next   = (word_masked[13:0] != 14'd0) ? PH_DUMP : PH_OPCODE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign push = accept && (frame_start || cmd.has_cmd);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      pending  <= 15'd0;
      word_low <= 8'd0;
    end else if (accept) begin
      phase    <= phase_next;
      pending  <= pending_next;
      word_low <= word_low_next;
    end
  end

endmodule

[hw/rtl/rsd_queue.sv]
module rsd_queue
  import rsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/rsd_back.sv]
module rsd_back
  import rsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] frame_size,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        op_valid,
  input  logic        op_stall,
  output logic [1:0]  op_kind,
  output logic [15:0] position,
  output logic [7:0]  pixel_value,
  output logic [14:0] pixel_count,
  output logic        frame_done
);

  logic        active, active_next;
  logic [15:0] pixels_left, pixels_left_next;
  logic [15:0] write_position, write_position_next;
  logic [15:0] left_cur, pos_cur, count_ext, clamped, left_after;
  logic        active_cur, is_end, emit;

  assign left_cur   = head.start ? frame_size : pixels_left;
  assign active_cur = head.start ? (frame_size != 16'd0) : active;
  assign pos_cur    = head.start ? 16'd0 : write_position;
  assign count_ext  = {1'b0, head.count};
  assign clamped    = (count_ext < left_cur) ? count_ext : left_cur;
  assign left_after = left_cur - clamped;
  assign is_end     = (head.kind == KIND_END);

  // Commands that arrive after the frame has finished are dropped here,
  // since the parser cannot see the pixel budget.
  assign emit = head.has_cmd && active_cur && (is_end || clamped != 16'd0);

  always_comb begin
    active_next         = active_cur;
    pixels_left_next    = left_cur;
    write_position_next = pos_cur;
    if (emit) begin
      if (is_end) begin
        active_next = 1'b0;
      end else begin
        pixels_left_next    = left_after;
        write_position_next = pos_cur + clamped;
        active_next         = (left_after != 16'd0);
      end
    end
  end

  assign pop = head_valid && (!op_valid || !op_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      pixels_left    <= 16'd0;
      write_position <= 16'd0;
      op_valid       <= 1'b0;
    end else begin
      if (pop) begin
        active         <= active_next;
        pixels_left    <= pixels_left_next;
        write_position <= write_position_next;
        op_valid       <= emit;
      end else if (!op_stall) begin
        op_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      op_kind     <= head.kind;
      position    <= pos_cur;
      pixel_value <= head.value;
      pixel_count <= is_end ? 15'd0 : clamped[14:0];
      frame_done  <= is_end || (left_after == 16'd0);
    end
  end

endmodule

[hw/rtl/rsd_checker.sv]
module rsd_checker
  import rsd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        op_valid,
  input logic        op_stall,
  input logic [1:0]  op_kind,
  input logic [15:0] position,
  input logic [7:0]  pixel_value,
  input logic [14:0] pixel_count,
  input logic        frame_done
);

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !op_valid)
    else $error("output valid after reset");

  a_end_completes_frame: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_kind == KIND_END) |-> (frame_done && pixel_count == 15'd0))
    else $error("end code without frame completion");

  a_literal_single: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_kind == KIND_LITERAL) |-> pixel_count == 15'd1)
    else $error("literal item covers other than one pixel");

  a_skip_no_value: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_kind == KIND_SKIP) |-> (pixel_value == 8'd0 && pixel_count != 15'd0))
    else $error("skip item with value or empty count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_stall) |=> (op_valid && $stable(position) && $stable(pixel_count)))
    else $error("stalled item changed");

endmodule

bind run_skip_dump_frame_decoder_core rsd_checker u_rsd_checker (.*);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rsd_pkg::*;

  typedef enum logic [2:0] {
    ST_OPCODE,
    ST_DUMP,
    ST_RUNCOUNT,
    ST_RUNVALUE,
    ST_WORDLOW,
    ST_WORDHIGH,
    ST_IDLE
  } parse_state_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] pos;
    logic [7:0]  value;
    logic [14:0] count;
    logic        done;
  } pixel_op_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] frame_pixels;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic        op_valid;
  logic        op_stall = 1'b0;
  logic [1:0]  op_kind;
  logic [15:0] position;
  logic [7:0]  pixel_value;
  logic [14:0] pixel_count;
  logic        frame_done;

  // Decoder model state.
  parse_state_t parse_st = ST_IDLE;
  logic [15:0]  frame_size_cfg = FRAME_PIXELS_RESET;
  logic [15:0]  run_len = '0;
  logic [15:0]  pixels_remaining = '0;
  logic [15:0]  write_pos = '0;
  logic [7:0]   word_lo = '0;

  pixel_op_t    expected_ops[$];
  logic [7:0]   frame_bytes[$];
  int           sent_bytes = 0;
  int           mismatches = 0;
  int           ops_taken = 0;
  int           byte_gap_max = 8;
  int           op_stall_max = 8;

  run_skip_dump_frame_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .frame_pixels (frame_pixels),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .frame_start  (frame_start),
    .op_valid     (op_valid),
    .op_stall     (op_stall),
    .op_kind      (op_kind),
    .position     (position),
    .pixel_value  (pixel_value),
    .pixel_count  (pixel_count),
    .frame_done   (frame_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("run_skip_dump_frame_decoder_core: mismatch");
    $finish;
  end

  // Clamp a command to the pixels left and record the op it produces.
  task automatic issue_op(input kind_t kind, input logic [7:0] value, input logic [15:0] cnt);
    logic [15:0] n;
    pixel_op_t   op;
    n = (cnt < pixels_remaining) ? cnt : pixels_remaining;
    if (n != 16'd0) begin
      op.kind = kind;
      op.pos = write_pos;
      op.value = value;
      op.count = n[14:0];
      pixels_remaining = pixels_remaining - n;
      write_pos = write_pos + n;
      op.done = (pixels_remaining == 16'd0);
      if (pixels_remaining == 16'd0) begin
        parse_st = ST_IDLE;
      end
      expected_ops.push_back(op);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fs);
    logic [15:0] w;
    pixel_op_t   op;
    if (fs) begin
      pixels_remaining = frame_size_cfg;
      write_pos = '0;
      run_len = '0;
      word_lo = '0;
      parse_st = (frame_size_cfg != 16'd0) ? ST_OPCODE : ST_IDLE;
    end
    sent_bytes++;
    case (parse_st)
      ST_OPCODE: begin
        if (b == 8'd0) begin
          parse_st = ST_RUNCOUNT;
        end else if (b < LONG_OPCODE) begin
          run_len = {8'd0, b};
          parse_st = ST_DUMP;
        end else if (b == LONG_OPCODE) begin
          parse_st = ST_WORDLOW;
        end else begin
          issue_op(KIND_SKIP, 8'd0, {8'd0, b & BYTE_SIGN_MASK});
        end
      end
      ST_DUMP: begin
        if (run_len != 16'd0) begin
          run_len = run_len - 16'd1;
        end
        if (run_len == 16'd0) begin
          parse_st = ST_OPCODE;
        end
        issue_op(KIND_LITERAL, b, 16'd1);
      end
      ST_RUNCOUNT: begin
        run_len = {8'd0, b};
        parse_st = ST_RUNVALUE;
      end
      ST_RUNVALUE: begin
        parse_st = ST_OPCODE;
        issue_op(KIND_FILL, b, run_len);
      end
      ST_WORDLOW: begin
        word_lo = b;
        parse_st = ST_WORDHIGH;
      end
      ST_WORDHIGH: begin
        w = {b, word_lo};
        parse_st = ST_OPCODE;
        if (w == 16'd0) begin
          // The end code is reported even though no pixels are covered.
          op.kind = KIND_END;
          op.pos = write_pos;
          op.value = '0;
          op.count = '0;
          op.done = 1'b1;
          expected_ops.push_back(op);
          parse_st = ST_IDLE;
        end else if (w < 16'h8000) begin
          issue_op(KIND_SKIP, 8'd0, w);
        end else begin
          w = w & WORD_SIGN_MASK;
          if (w >= LONG_RUN_BIT) begin
            run_len = w - LONG_RUN_BIT;
            parse_st = ST_RUNVALUE;
          end else begin
            run_len = w;
            parse_st = (w != 16'd0) ? ST_DUMP : ST_OPCODE;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = $urandom_range(0, byte_gap_max);
    if (gap > 0) begin
      byte_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid = 1'b1;
    data_byte = b;
    frame_start = fs;
    do @(posedge clk); while (byte_stall);
    decode_byte(b, fs);
    @(negedge clk);
    byte_valid = 1'b0;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == 0);
    end
  endtask

  task automatic wait_drained();
    while (expected_ops.size() != 0) @(negedge clk);
    // A trailing byte that produced nothing may still be in the pipeline.
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frame_size(input logic [15:0] v);
    wait_drained();
    cfg_valid = 1'b1;
    frame_pixels = v;
    do @(posedge clk); while (!cfg_ready);
    frame_size_cfg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Builds one frame of mostly well formed commands with random content.
  task automatic build_frame();
    int          n_cmds;
    int          r;
    int          n;
    logic [15:0] w;
    bit          cut;
    frame_bytes.delete();
    n_cmds = $urandom_range(1, 10);
    cut = 1'b0;
    for (int c = 0; c < n_cmds && !cut; c++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 127);
        frame_bytes.push_back(n[7:0]);
        for (int k = 0; k < n && k < 24; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
        cut = (n > 24);
      end else if (r < 42) begin
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 55) begin
        frame_bytes.push_back(8'($urandom_range(8'h81, 8'hff)));
      end else if (r < 63) begin
        w = 16'($urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 16'h7fff));
        frame_bytes.push_back(LONG_OPCODE);
        frame_bytes.push_back(w[7:0]);
        frame_bytes.push_back(w[15:8]);
      end else if (r < 71) begin
        w = 16'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 12)
                                              : $urandom_range(0, 16'h3fff));
        frame_bytes.push_back(LONG_OPCODE);
        frame_bytes.push_back(w[7:0]);
        frame_bytes.push_back(8'h80 | w[13:8]);
        for (int k = 0; k < w && k < 24; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
        cut = (w > 16'd24);
      end else if (r < 79) begin
        w = 16'($urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 16'h3fff));
        frame_bytes.push_back(LONG_OPCODE);
        frame_bytes.push_back(w[7:0]);
        frame_bytes.push_back(8'hc0 | w[13:8]);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 85) begin
        frame_bytes.push_back(LONG_OPCODE);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        cut = ($urandom_range(0, 1) != 0);
      end else if (r < 90) begin
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        // Broken long opcode: the next frame start abandons it.
        frame_bytes.push_back(LONG_OPCODE);
        if ($urandom_range(0, 1)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        cut = 1'b1;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_opcodes();
    // A byte before any frame start is ignored.
    send_byte(8'h01, 1'b0);
    frame_bytes = '{8'h01, 8'hff,
                    8'h00, 8'h00, 8'h55,
                    8'h00, 8'hff, 8'haa,
                    8'hff,
                    8'h80, 8'hff, 8'h7f,
                    8'h80, 8'h01, 8'h80, 8'h00,
                    8'h80, 8'hff, 8'hff, 8'h5a,
                    8'h80, 8'h00, 8'h00,
                    8'h81};
    send_frame();
  endtask

  task automatic test_frame_edges();
    // One pixel: the dump is cut short when the frame fills.
    set_frame_size(16'd1);
    frame_bytes = '{8'h05, 8'h11, 8'h22};
    send_frame();
    // Largest frame: a run abandoned by a restart, then skips clamped at the end.
    set_frame_size(16'hffff);
    frame_bytes = '{8'h00, 8'h09};
    send_frame();
    frame_bytes = '{8'h83, 8'h80, 8'hff, 8'h7f, 8'h80, 8'hff, 8'h7f, 8'h02};
    send_frame();
  endtask

  task automatic test_random_frames();
    logic [15:0] size;
    int          target;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 6: size = 16'hffff;
        1: size = 16'd1;
        2, 5: size = 16'($urandom_range(2, 40));
        3: size = 16'($urandom_range(41, 500));
        4: size = 16'($urandom_range(1, 16'hffff));
        default: size = 16'($urandom_range(500, 4000));
      endcase
      set_frame_size(size);
      byte_gap_max = (p % 3 == 0) ? 0 : 8;
      op_stall_max = (p % 4 == 1) ? 0 : 8;
      target = sent_bytes + 222;
      while (sent_bytes < target) begin
        build_frame();
        send_frame();
      end
    end
    byte_gap_max = 8;
    op_stall_max = 8;
  endtask

  // Output stall: a fresh wait is drawn after every accepted op.
  always @(negedge clk) begin : stall_gen
    int seen;
    int hold;
    if (seen != ops_taken) begin
      seen = ops_taken;
      hold = $urandom_range(0, op_stall_max);
    end
    op_stall <= (hold != 0);
    if (hold != 0) hold--;
  end

  always @(posedge clk) begin
    pixel_op_t want;
    if (!rst && op_valid && !op_stall) begin
      ops_taken++;
      if (expected_ops.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected op: kind %0d pos %0d value %0d count %0d done %0b",
                   op_kind, position, pixel_value, pixel_count, frame_done);
        end
      end else begin
        want = expected_ops.pop_front();
        if (op_kind !== want.kind || position !== want.pos || pixel_value !== want.value ||
            pixel_count !== want.count || frame_done !== want.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("op differs: expected kind %0d pos %0d value %0d count %0d done %0b",
                     want.kind, want.pos, want.value, want.count, want.done);
            $display("              actual kind %0d pos %0d value %0d count %0d done %0b",
                     op_kind, position, pixel_value, pixel_count, frame_done);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    frame_pixels = '0;
    byte_valid = 1'b0;
    data_byte = '0;
    frame_start = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_opcodes();
    test_frame_edges();
    test_random_frames();

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_ops.size() == 0) begin
      $display("run_skip_dump_frame_decoder_core: match");
    end else begin
      $display("run_skip_dump_frame_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

[run_skip_dump_frame_decoder_core.f]
hw/rtl/rsd_pkg.sv
hw/rtl/rsd_front.sv
hw/rtl/rsd_queue.sv
hw/rtl/rsd_back.sv
hw/rtl/run_skip_dump_frame_decoder_core.sv
hw/rtl/rsd_checker.sv
bench/tb.sv
